// File: sv/hbef_pkg.sv
// Headset button event filter: shared types and constants.
// No dependencies; imported by hbef_core and the top level.
package hbef_pkg;

   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned LOCKOUT_W  = 32;
   localparam int unsigned TIME_W     = 64;

   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 32'd300000;

   // Bit positions inside the status and key bytes
   localparam int unsigned ACC_INSERTED = 3;
   localparam int unsigned KEY_PLAY_PRESS = 0;
   localparam int unsigned KEY_VUP_PRESS  = 4;
   localparam int unsigned KEY_VDN_PRESS  = 6;

   typedef enum logic [1:0] {
      KEY_NONE     = 2'd0,
      KEY_PLAY     = 2'd1,
      KEY_VOL_UP   = 2'd2,
      KEY_VOL_DOWN = 2'd3
   } key_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_us;
      logic [7:0]        key_flags;
      logic [7:0]        accessory_status;
      logic [7:0]        interrupt_flags;
   } req_type;

   typedef struct packed {
      logic       keypad_enable_request;
      logic       mic_status;
      logic       jack_plugged;
      logic       button_level;
      logic [1:0] button_id;
      logic       button_valid;
   } rsp_type;

endpackage

// File: sv/hbef_core.sv
// Headset button event filter: jack/mic status tracking, key decode and lockout.
// Holds the filter state; depends on hbef_pkg.
module hbef_core import hbef_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              word_in,
   input  logic                 fire,
   input  logic [LOCKOUT_W-1:0] lockout,
   output rsp_type              result
);

   logic              plugged_ff, plugged_in;
   logic              mic_ff, mic_in;
   key_type           last_key_ff, last_key_in;
   logic [TIME_W-1:0] last_rel_ff, last_rel_in;

   logic              irq_hit;
   logic              mic_new;
   logic [TIME_W-1:0] rel_base;
   logic [TIME_W-1:0] gap_us;
   key_type           key;
   logic              press;
   logic              blocked;
   logic              take;

   always_comb begin
      irq_hit = |word_in.interrupt_flags[1:0];
      mic_new = word_in.accessory_status[ACC_INSERTED] & (|word_in.accessory_status[2:1]);
      plugged_in = irq_hit ? word_in.accessory_status[ACC_INSERTED] : plugged_ff;
      mic_in     = irq_hit ? mic_new : mic_ff;

      // Time zero restarts the release clock
      rel_base = (word_in.now_us == '0) ? '0 : last_rel_ff;

      key   = KEY_NONE;
      press = 1'b0;
      if (|word_in.key_flags[1:0]) begin
         key   = KEY_PLAY;
         press = word_in.key_flags[KEY_PLAY_PRESS];
      end else if (|word_in.key_flags[5:4]) begin
         key   = KEY_VOL_UP;
         press = word_in.key_flags[KEY_VUP_PRESS];
      end else if (|word_in.key_flags[7:6]) begin
         key   = KEY_VOL_DOWN;
         press = word_in.key_flags[KEY_VDN_PRESS];
      end

      gap_us  = word_in.now_us - rel_base;
      blocked = (last_key_ff != key) &&
                (gap_us[TIME_W-1:LOCKOUT_W] == '0) && (gap_us[LOCKOUT_W-1:0] < lockout);
      take    = mic_in && (key != KEY_NONE) && !blocked;

      last_key_in = take ? key : last_key_ff;
      if (take && !press) begin
         last_rel_in = word_in.now_us;
      end else if (mic_in) begin
         last_rel_in = rel_base;
      end else begin
         last_rel_in = last_rel_ff;
      end

      result.button_valid          = take;
      result.button_id             = take ? 2'(key - 2'd1) : 2'd0;
      result.button_level          = take & press;
      result.jack_plugged          = plugged_in;
      result.mic_status            = mic_in;
      result.keypad_enable_request = irq_hit & mic_new & ~mic_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plugged_ff  <= 1'b0;
         mic_ff      <= 1'b0;
         last_key_ff <= KEY_NONE;
         last_rel_ff <= '0;
      end else if (fire) begin
         plugged_ff  <= plugged_in;
         mic_ff      <= mic_in;
         last_key_ff <= last_key_in;
         last_rel_ff <= last_rel_in;
      end
   end

   // Mic can only be flagged while the jack is plugged
   a_mic_needs_plug: assert property (@(posedge clock) disable iff (reset)
      mic_ff |-> plugged_ff)
      else $error("mic flag set while unplugged");

   // A dropped or absent event leaves the last key alone
   a_key_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && !take) |=> $stable(last_key_ff))
      else $error("last key changed without a report");

   // An accepted release records its time
   a_release_key: assert property (@(posedge clock) disable iff (reset)
      (fire && take && !press) |=> (last_rel_ff == $past(word_in.now_us)))
      else $error("release time not recorded");

endmodule

// File: sv/headset_button_event_filter_top.sv
// Headset button event filter, top level: input register, filter core, result register.
// Depends on hbef_pkg and hbef_core.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata[87:0]
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata[7:0]
//  csr     | in  | csr_wr_en              | csr_wr_data[31:0] (lockout_time)
//
// One word in per cycle unless a result stalls; one result word out per input word.
// The filter state updates as a word moves from the input register to the result
// register; the word behind it then reaches the core and sees the update.
// Reset is synchronous; it empties both registers, clears the state and loads
// lockout_time with 300000. A stalled result holds the input register, and
// req_tready falls while both registers are full and rsp_tready is low.
module headset_button_event_filter_top import hbef_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // interrupt_flags[7:0], accessory_status[15:8], key_flags[23:16], now_us[87:24]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // button_valid[0], button_id[2:1], button_level[3], jack_plugged[4],
   // mic_status[5], keypad_enable_request[6], zero[7]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [LOCKOUT_W-1:0]  csr_wr_data
);

   logic                 s1_valid_ff;
   req_type              s1_word_ff;
   logic                 out_valid_ff;
   rsp_type              out_word_ff;
   logic [LOCKOUT_W-1:0] lockout_ff;
   logic                 advance;
   rsp_type              result;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   hbef_core u_core (
      .clock   (clock),
      .reset   (reset),
      .word_in (s1_word_ff),
      .fire    (advance),
      .lockout (lockout_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         lockout_ff   <= LOCKOUT_RESET;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            lockout_ff <= csr_wr_data;
         end
      end
   end

   // Payload: load on handshake only
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_word_ff <= req_type'(req_tdata);
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_word_ff};

   // A full input register must not be overwritten while it cannot drain
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_tready)
      else $error("input register overwritten");

   // No report means id and level are zero
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[3:1] == 3'd0))
      else $error("id or level set without a report");

   // Keypad request only with a present microphone
   a_kp_with_mic: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6]) |-> rsp_tdata[5])
      else $error("keypad request without microphone");

   // A word that moves on yields a result in the next cycle
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("result lost");

endmodule
